[hw/rtl/lert_pkg.sv]
// Package for the edge rule table: sizes, codes, FSM states and control structs.
package lert_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = 7;

    typedef logic [2:0] op_t;
    localparam op_t OP_STEP      = 3'd0;
    localparam op_t OP_LEARN     = 3'd1;
    localparam op_t OP_REMOVE    = 3'd2;
    localparam op_t OP_CLEAR     = 3'd3;
    localparam op_t OP_LOAD_OUT  = 3'd4;
    localparam op_t OP_LOAD_PAGE = 3'd5;

    typedef logic [3:0] status_t;
    localparam status_t ST_NONE    = 4'd0;
    localparam status_t ST_NO_RULE = 4'd1;
    localparam status_t ST_GLOBAL  = 4'd2;
    localparam status_t ST_HERE    = 4'd3;
    localparam status_t ST_ABOVE   = 4'd4;
    localparam status_t ST_BELOW   = 4'd5;
    localparam status_t ST_CREATED = 4'd6;
    localparam status_t ST_FULL    = 4'd7;
    localparam status_t ST_CLEARED = 4'd8;
    localparam status_t ST_LOADED  = 4'd9;

    localparam logic [7:0] PAGE_EMPTY  = 8'd0;
    localparam logic [7:0] PAGE_GLOBAL = 8'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_WAIT,
        S_PICK,
        S_EXEC,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic latch;
        logic scan_clear;
        logic scan_issue;
        logic pick_read;
        logic exec;
        logic publish;
    } dp_cmd_t;

    typedef struct packed {
        logic needs_scan;
        logic scan_last;
        logic res_free;
    } dp_stat_t;

    typedef struct packed {
        logic [7:0]  page;
        logic [15:0] fb;
        logic [7:0]  fall;
        logic [7:0]  rise;
        logic [15:0] mask;
        logic [15:0] clr;
        logic [15:0] set;
    } rule_t;

endpackage

[hw/rtl/learning_edge_rule_table.sv]
// Sequence: step and remove with an input edge, and learn with an edge and a nonzero page,
// run decode, a 64-entry scan through the rule memory read port, wait, pick read, execute
// and publish; every other transaction runs decode, execute and publish.
// Flow: one transaction in flight; the next is accepted in the cycle after publish at the
// earliest; a result held in the output register delays publish.
// Reset: all entries empty, output, page, last input and count zero; no clearing pass.
module learning_edge_rule_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  operation,
    input  logic [7:0]  in_byte,
    input  logic [15:0] next_value,
    input  logic [15:0] rule_mask_in,
    input  logic [7:0]  page_value,
    input  logic [15:0] load_output,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  status,
    output logic [15:0] output_value,
    output logic [7:0]  current_page,
    output logic [6:0]  used_entries
);
    import lert_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    lert_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    lert_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .operation    (operation),
        .in_byte      (in_byte),
        .next_value   (next_value),
        .rule_mask_in (rule_mask_in),
        .page_value   (page_value),
        .load_output  (load_output),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .output_value (output_value),
        .current_page (current_page),
        .used_entries (used_entries)
    );

endmodule

[hw/rtl/lert_ctrl.sv]
// Sequencer for the edge rule table: accept, table scan, execute, publish.
module lert_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  lert_pkg::dp_stat_t stat,
    output lert_pkg::dp_cmd_t  cmd
);
    import lert_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = stat.needs_scan ? S_SCAN : S_EXEC;
            end
            S_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:   state_next = S_PICK;
            S_PICK:   state_next = S_EXEC;
            S_EXEC:   state_next = S_FINISH;
            S_FINISH:
            begin
                if (stat.res_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall       = (state_reg != S_IDLE);
        cmd            = '0;
        cmd.latch      = (state_reg == S_IDLE) && in_valid;
        cmd.scan_clear = (state_reg == S_DECODE);
        cmd.scan_issue = (state_reg == S_SCAN);
        cmd.pick_read  = (state_reg == S_PICK);
        cmd.exec       = (state_reg == S_EXEC);
        cmd.publish    = (state_reg == S_FINISH) && stat.res_free;
    end

endmodule

[hw/rtl/lert_dp.sv]
// Datapath for the edge rule table: rule memory, scan trackers, state and result registers.
module lert_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  lert_pkg::dp_cmd_t  cmd,
    output lert_pkg::dp_stat_t stat,
    input  logic [2:0]         operation,
    input  logic [7:0]         in_byte,
    input  logic [15:0]        next_value,
    input  logic [15:0]        rule_mask_in,
    input  logic [7:0]         page_value,
    input  logic [15:0]        load_output,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [3:0]         status,
    output logic [15:0]        output_value,
    output logic [7:0]         current_page,
    output logic [6:0]         used_entries
);
    import lert_pkg::*;

    // latched transaction
    op_t         op_reg;
    logic [7:0]  byte_reg;
    logic [15:0] next_reg;
    logic [15:0] mask_reg;
    logic [7:0]  pval_reg;
    logic [15:0] lval_reg;

    // architectural state
    logic [7:0]         last_reg;
    logic [15:0]        out_reg;
    logic [7:0]         page_reg;
    logic [CNT_W-1:0]   used_reg;
    logic [ENTRIES-1:0] valid_reg;
    status_t            status_reg;

    // scan
    logic [IDX_W-1:0] addr_reg;
    logic             q_vld_reg;
    logic [IDX_W-1:0] q_idx_reg;
    rule_t            q_reg;
    rule_t            mem [ENTRIES];

    logic             hit_ok_reg;
    status_t          hit_code_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic             up_ok_reg;
    logic [7:0]       up_pg_reg;
    logic [IDX_W-1:0] up_idx_reg;
    logic             dn_ok_reg;
    logic [7:0]       dn_pg_reg;
    logic [IDX_W-1:0] dn_idx_reg;
    logic             dup_reg;
    logic             free_ok_reg;
    logic [IDX_W-1:0] free_idx_reg;

    // result
    logic        res_valid_reg;
    status_t     res_status_reg;
    logic [15:0] res_out_reg;
    logic [7:0]  res_page_reg;
    logic [6:0]  res_used_reg;

    logic [7:0]       fall;
    logic [7:0]       rise;
    logic             has_edge;
    logic             v;
    logic             em;
    logic             fb_ok;
    logic             is_global;
    logic             is_local;
    logic             is_here;
    logic             is_up;
    logic             is_dn;
    logic             is_dup;
    status_t          sel;
    logic [IDX_W-1:0] pick;
    logic [IDX_W-1:0] rd_addr;
    rule_t            new_rule;
    logic             wr_en;

    assign fall     = last_reg & ~byte_reg;
    assign rise     = byte_reg & ~last_reg;
    assign has_edge = |(fall | rise);

    assign stat.needs_scan = has_edge && ((op_reg == OP_STEP) || (op_reg == OP_REMOVE) ||
                             ((op_reg == OP_LEARN) && (pval_reg != PAGE_EMPTY)));
    assign stat.scan_last  = (addr_reg == IDX_W'(ENTRIES - 1));
    assign stat.res_free   = !res_valid_reg || !out_stall;

    // per-entry match on the word returned by the memory
    assign v         = q_vld_reg && valid_reg[q_idx_reg];
    assign em        = v && (q_reg.fall == fall) && (q_reg.rise == rise);
    assign fb_ok     = (q_reg.fb & q_reg.mask) == (out_reg & q_reg.mask);
    assign is_global = em && (q_reg.page == PAGE_GLOBAL);
    assign is_local  = em && (q_reg.page != PAGE_GLOBAL) && fb_ok;
    assign is_here   = is_local && (q_reg.page == page_reg);
    assign is_up     = is_local && (q_reg.page > page_reg);
    assign is_dn     = is_local && (q_reg.page < page_reg);
    assign is_dup    = em && ((q_reg.page == PAGE_GLOBAL) || ((q_reg.page == pval_reg) &&
                       ((q_reg.fb & mask_reg) == (out_reg & mask_reg))));

    always_comb
    begin
        priority if (hit_ok_reg)
        begin
            sel  = hit_code_reg;
            pick = hit_idx_reg;
        end
        else if (up_ok_reg)
        begin
            sel  = ST_ABOVE;
            pick = up_idx_reg;
        end
        else if (dn_ok_reg)
        begin
            sel  = ST_BELOW;
            pick = dn_idx_reg;
        end
        else
        begin
            sel  = ST_NO_RULE;
            pick = '0;
        end
    end

    assign rd_addr = cmd.pick_read ? pick : addr_reg;

    always_comb
    begin
        new_rule      = '0;
        new_rule.page = pval_reg;
        new_rule.fb   = out_reg;
        new_rule.fall = fall;
        new_rule.rise = rise;
        new_rule.mask = mask_reg;
        if (pval_reg > PAGE_GLOBAL)
        begin
            new_rule.clr = out_reg & ~next_reg & mask_reg;
            new_rule.set = next_reg & ~out_reg & mask_reg;
        end
        else
        begin
            new_rule.clr = ~next_reg & mask_reg;
            new_rule.set = next_reg & mask_reg;
        end
    end

    assign wr_en = cmd.exec && (op_reg == OP_LEARN) && stat.needs_scan && !dup_reg &&
                   free_ok_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[free_idx_reg] <= new_rule;
        end
        q_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg   <= operation;
            byte_reg <= in_byte;
            next_reg <= next_value;
            mask_reg <= rule_mask_in;
            pval_reg <= page_value;
            lval_reg <= load_output;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg     <= '0;
            out_reg      <= '0;
            page_reg     <= '0;
            used_reg     <= '0;
            valid_reg    <= '0;
            status_reg   <= ST_NONE;
            addr_reg     <= '0;
            q_vld_reg    <= 1'b0;
            q_idx_reg    <= '0;
            hit_ok_reg   <= 1'b0;
            hit_code_reg <= ST_NONE;
            hit_idx_reg  <= '0;
            up_ok_reg    <= 1'b0;
            up_pg_reg    <= '0;
            up_idx_reg   <= '0;
            dn_ok_reg    <= 1'b0;
            dn_pg_reg    <= '0;
            dn_idx_reg   <= '0;
            dup_reg      <= 1'b0;
            free_ok_reg  <= 1'b0;
            free_idx_reg <= '0;
        end
        else
        begin
            q_vld_reg <= cmd.scan_issue;
            q_idx_reg <= addr_reg;

            if (cmd.scan_clear)
            begin
                addr_reg    <= '0;
                hit_ok_reg  <= 1'b0;
                up_ok_reg   <= 1'b0;
                dn_ok_reg   <= 1'b0;
                dup_reg     <= 1'b0;
                free_ok_reg <= 1'b0;
            end
            else
            begin
                if (cmd.scan_issue)
                begin
                    addr_reg <= addr_reg + IDX_W'(1);
                end
                // first global or same-page rule wins outright
                if (!hit_ok_reg && (is_global || is_here))
                begin
                    hit_ok_reg   <= 1'b1;
                    hit_code_reg <= is_global ? ST_GLOBAL : ST_HERE;
                    hit_idx_reg  <= q_idx_reg;
                end
                if (is_up && (!up_ok_reg || (q_reg.page < up_pg_reg)))
                begin
                    up_ok_reg  <= 1'b1;
                    up_pg_reg  <= q_reg.page;
                    up_idx_reg <= q_idx_reg;
                end
                if (is_dn && (!dn_ok_reg || (q_reg.page > dn_pg_reg)))
                begin
                    dn_ok_reg  <= 1'b1;
                    dn_pg_reg  <= q_reg.page;
                    dn_idx_reg <= q_idx_reg;
                end
                if (is_dup)
                begin
                    dup_reg <= 1'b1;
                end
                if (q_vld_reg && !valid_reg[q_idx_reg] && !free_ok_reg)
                begin
                    free_ok_reg  <= 1'b1;
                    free_idx_reg <= q_idx_reg;
                end
            end

            if (cmd.exec)
            begin
                unique case (op_reg)
                    OP_STEP:
                    begin
                        status_reg <= has_edge ? sel : ST_NONE;
                        if (has_edge)
                        begin
                            last_reg <= byte_reg;
                            if (sel != ST_NO_RULE)
                            begin
                                out_reg  <= (out_reg | (q_reg.set & q_reg.mask)) &
                                            ~(q_reg.clr & q_reg.mask);
                                page_reg <= q_reg.page;
                            end
                        end
                    end
                    OP_LEARN:
                    begin
                        if (stat.needs_scan && !dup_reg)
                        begin
                            if (free_ok_reg)
                            begin
                                valid_reg[free_idx_reg] <= 1'b1;
                                used_reg                <= used_reg + CNT_W'(1);
                                status_reg              <= ST_CREATED;
                            end
                            else
                            begin
                                status_reg <= ST_FULL;
                            end
                        end
                        else
                        begin
                            status_reg <= ST_NONE;
                        end
                    end
                    OP_REMOVE:
                    begin
                        status_reg <= has_edge ? sel : ST_NONE;
                        if (has_edge && (sel != ST_NO_RULE))
                        begin
                            valid_reg[pick] <= 1'b0;
                            used_reg        <= used_reg - CNT_W'(1);
                        end
                    end
                    OP_CLEAR:
                    begin
                        valid_reg  <= '0;
                        used_reg   <= '0;
                        out_reg    <= '0;
                        status_reg <= ST_CLEARED;
                    end
                    OP_LOAD_OUT:
                    begin
                        out_reg    <= lval_reg;
                        status_reg <= ST_LOADED;
                    end
                    OP_LOAD_PAGE:
                    begin
                        page_reg   <= pval_reg;
                        status_reg <= ST_LOADED;
                    end
                    default:
                    begin
                        status_reg <= ST_NONE;
                    end
                endcase
            end
        end
    end

    // output register: a finished transaction waits here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            res_status_reg <= status_reg;
            res_out_reg    <= out_reg;
            res_page_reg   <= page_reg;
            res_used_reg   <= 7'(used_reg);
        end
    end

    assign out_valid    = res_valid_reg;
    assign status       = res_status_reg;
    assign output_value = res_out_reg;
    assign current_page = res_page_reg;
    assign used_entries = res_used_reg;

    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        32'(used_reg) == $countones(valid_reg))
        else $error("entry count out of step with valid bits");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(used_reg) <= ENTRIES)
        else $error("entry count above table size");

    a_pick_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && (op_reg == OP_REMOVE || op_reg == OP_STEP) && has_edge &&
         sel != ST_NO_RULE) |-> valid_reg[pick])
        else $error("selected rule entry is empty");

endmodule
